>>> rtl/core/srcap_pkg.sv
// shared constants, command codes and types for the sensor ring capture block
// no dependencies; compiled first
package srcap_pkg;

  localparam int RING_DEPTH = 32;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  localparam logic [7:0] ALIVE_BYTE = 8'h55;
  localparam logic [7:0] ACK_BYTE   = 8'h33;
  localparam logic [7:0] STOP_BYTE  = 8'h16;

  localparam logic [7:0] CMD_ACK       = 8'd0;
  localparam logic [7:0] CMD_RD_LIGHT  = 8'd1;
  localparam logic [7:0] CMD_RD_MIC    = 8'd2;
  localparam logic [7:0] CMD_RD_LOUD   = 8'd3;
  localparam logic [7:0] CMD_THR_LIGHT = 8'd4;
  localparam logic [7:0] CMD_THR_LOUD  = 8'd5;
  localparam logic [7:0] CMD_FETCH     = 8'd6;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CMD  = 1'b1;

  // request to the shared threshold compare unit
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] thr;
  } cmp_req_t;

endpackage

>>> rtl/core/srcap_if.sv
// valid/ready channel interfaces for sample/command transactions and reply bytes
// depends on nothing but plain logic types
interface srcap_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [9:0] light_sample;
  logic [9:0] mic_sample;
  logic [9:0] loud_sample;
  logic [7:0] command;
  logic [7:0] argument;

  modport source (output valid, op, light_sample, mic_sample, loud_sample, command,
                  argument, input ready);
  modport sink (input valid, op, light_sample, mic_sample, loud_sample, command,
                argument, output ready);
endinterface

interface srcap_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       last;
  logic [1:0] irq_pulses;
  logic       light_hit;
  logic       loud_hit;

  modport source (output valid, reply_byte, last, irq_pulses, light_hit, loud_hit,
                  input ready);
  modport sink (input valid, reply_byte, last, irq_pulses, light_hit, loud_hit,
                output ready);
endinterface

>>> rtl/core/srcap_ram.sv
// generic single-write, single-read ram with registered read data
// no package dependencies
module srcap_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/srcap_cmp.sv
// shared threshold compare unit: signed byte compare, zero threshold disables
// depends on srcap_pkg for the request struct
module srcap_cmp (
  input  srcap_pkg::cmp_req_t req,
  output logic                hit
);

  // reached when value >= threshold as signed bytes
  always_comb begin
    hit = (req.thr != 8'd0) && ($signed(req.value) >= $signed(req.thr));
  end

endmodule

>>> rtl/core/sensor_ring_capture_with_spi_readout.sv
// top level: sequencer, ring buffers, thresholds and reply byte register
// depends on srcap_pkg, srcap_if, srcap_ram and srcap_cmp
//
// A sample tick writes one byte per sensor into three rings of RING_DEPTH
// entries; its one result is sent via S_TICK_L, S_TICK_D, S_TICK_OUT; the light
// and loudness threshold checks run one after the other through a single
// compare unit. A command returns 0x55 and the command echo, then its own
// bytes, one byte per cycle while the sink is ready: 2 bytes for an unknown
// command, 3 for ack or threshold set, 4 for fetch, and 4 + min(length,
// RING_DEPTH) for a buffer read with a positive length (4 otherwise), whose
// data bytes stream from the ring read port one per cycle.
// The block takes no new transaction until the last reply byte of the
// current one sits in the output register; it accepts the next one while that
// byte still waits to be taken. Ring contents are not cleared at reset.
module sensor_ring_capture_with_spi_readout (
  input logic         clk,
  input logic         rst_n,
  srcap_in_if.sink    in_ch,
  srcap_out_if.source out_ch
);

  localparam int PTR_W = srcap_pkg::PTR_W;
  localparam int CNT_W = srcap_pkg::CNT_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_TICK_L   = 4'd1;
  localparam logic [3:0] S_TICK_D   = 4'd2;
  localparam logic [3:0] S_TICK_OUT = 4'd3;
  localparam logic [3:0] S_ALIVE    = 4'd4;
  localparam logic [3:0] S_CMD      = 4'd5;
  localparam logic [3:0] S_ARG      = 4'd6;
  localparam logic [3:0] S_DATA     = 4'd7;
  localparam logic [3:0] S_FETCH    = 4'd8;
  localparam logic [3:0] S_LAST     = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       arg_r, arg_nxt;
  logic [7:0]       light_r, light_nxt;
  logic [7:0]       loud_r, loud_nxt;
  logic [1:0]       sel_r, sel_nxt;
  logic [7:0]       hold_r, hold_nxt;
  logic             lh_r, lh_nxt;
  logic             dh_r, dh_nxt;
  logic [PTR_W-1:0] light_wp_r, light_wp_nxt;
  logic [PTR_W-1:0] mic_wp_r, mic_wp_nxt;
  logic [PTR_W-1:0] loud_wp_r, loud_wp_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       light_thr_r, light_thr_nxt;
  logic [7:0]       loud_thr_r, loud_thr_nxt;
  logic [7:0]       light_lat_r, light_lat_nxt;
  logic [7:0]       loud_lat_r, loud_lat_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic [1:0]       out_irq_r, out_irq_nxt;
  logic             out_lh_r, out_lh_nxt;
  logic             out_dh_r, out_dh_nxt;

  logic             in_fire;
  logic             tick_wr;
  logic             out_free;
  logic             emit;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic [7:0]       light_q, mic_q, loud_q, ring_q;
  logic [CNT_W-1:0] sat_len;
  logic             cmp_hit;
  srcap_pkg::cmp_req_t cmp_req;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign tick_wr     = in_fire && (in_ch.op == srcap_pkg::OP_TICK);
  assign out_free    = !out_valid_r || out_ch.ready;

  // ring read steps downward from the current read index
  assign rd_addr = (rd_r == '0) ? PTR_W'(srcap_pkg::RING_DEPTH - 1) : rd_r - 1'b1;

  // read length: signed-negative or zero sends nothing, saturate at depth
  always_comb begin
    if (arg_r[7] || (arg_r == 8'd0)) begin
      sat_len = '0;
    end else if ({1'b0, arg_r} > 9'(srcap_pkg::RING_DEPTH)) begin
      sat_len = CNT_W'(srcap_pkg::RING_DEPTH);
    end else begin
      sat_len = CNT_W'(arg_r);
    end
  end

  // ring buffers
  srcap_ram #(.DEPTH(srcap_pkg::RING_DEPTH), .WIDTH(8)) u_light_ring (
    .clk(clk), .we(tick_wr), .waddr(light_wp_r), .wdata(in_ch.light_sample[7:0]),
    .re(rd_en), .raddr(rd_addr), .rdata(light_q)
  );
  srcap_ram #(.DEPTH(srcap_pkg::RING_DEPTH), .WIDTH(8)) u_mic_ring (
    .clk(clk), .we(tick_wr), .waddr(mic_wp_r), .wdata(in_ch.mic_sample[9:2]),
    .re(rd_en), .raddr(rd_addr), .rdata(mic_q)
  );
  srcap_ram #(.DEPTH(srcap_pkg::RING_DEPTH), .WIDTH(8)) u_loud_ring (
    .clk(clk), .we(tick_wr), .waddr(loud_wp_r), .wdata(in_ch.loud_sample[9:2]),
    .re(rd_en), .raddr(rd_addr), .rdata(loud_q)
  );

  // select the ring being read
  always_comb begin
    case (sel_r)
      2'd1:    ring_q = light_q;
      2'd2:    ring_q = mic_q;
      default: ring_q = loud_q;
    endcase
  end

  // shared compare unit, light then loudness
  assign cmp_req.value = (state_r == S_TICK_L) ? light_r : loud_r;
  assign cmp_req.thr   = (state_r == S_TICK_L) ? light_thr_r : loud_thr_r;

  srcap_cmp u_cmp (
    .req(cmp_req),
    .hit(cmp_hit)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    arg_nxt       = arg_r;
    light_nxt     = light_r;
    loud_nxt      = loud_r;
    sel_nxt       = sel_r;
    hold_nxt      = hold_r;
    lh_nxt        = lh_r;
    dh_nxt        = dh_r;
    light_wp_nxt  = light_wp_r;
    mic_wp_nxt    = mic_wp_r;
    loud_wp_nxt   = loud_wp_r;
    rd_nxt        = rd_r;
    cnt_nxt       = cnt_r;
    light_thr_nxt = light_thr_r;
    loud_thr_nxt  = loud_thr_r;
    light_lat_nxt = light_lat_r;
    loud_lat_nxt  = loud_lat_r;
    emit          = 1'b0;
    rd_en         = 1'b0;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_irq_nxt   = out_irq_r;
    out_lh_nxt    = out_lh_r;
    out_dh_nxt    = out_dh_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_ch.command;
          arg_nxt   = in_ch.argument;
          light_nxt = in_ch.light_sample[7:0];
          loud_nxt  = in_ch.loud_sample[9:2];
          if (in_ch.op == srcap_pkg::OP_TICK) begin
            light_wp_nxt = (32'(light_wp_r) + 1 >= srcap_pkg::RING_DEPTH) ? '0
                           : light_wp_r + 1'b1;
            mic_wp_nxt   = (32'(mic_wp_r) + 1 >= srcap_pkg::RING_DEPTH) ? '0
                           : mic_wp_r + 1'b1;
            loud_wp_nxt  = (32'(loud_wp_r) + 1 >= srcap_pkg::RING_DEPTH) ? '0
                           : loud_wp_r + 1'b1;
            state_nxt    = S_TICK_L;
          end else begin
            state_nxt = S_ALIVE;
          end
        end
      end
      S_TICK_L: begin
        lh_nxt = cmp_hit;
        if (cmp_hit) begin
          light_lat_nxt = light_r;
        end
        state_nxt = S_TICK_D;
      end
      S_TICK_D: begin
        dh_nxt = cmp_hit;
        if (cmp_hit) begin
          loud_lat_nxt = loud_r;
        end
        state_nxt = S_TICK_OUT;
      end
      S_TICK_OUT: begin
        if (out_free) begin
          emit         = 1'b1;
          out_byte_nxt = 8'd0;
          out_last_nxt = 1'b1;
          out_irq_nxt  = 2'd1 + {1'b0, lh_r} + {1'b0, dh_r};
          out_lh_nxt   = lh_r;
          out_dh_nxt   = dh_r;
          state_nxt    = S_IDLE;
        end
      end
      S_ALIVE: begin
        if (out_free) begin
          emit         = 1'b1;
          out_byte_nxt = srcap_pkg::ALIVE_BYTE;
          out_last_nxt = 1'b0;
          out_irq_nxt  = 2'd0;
          out_lh_nxt   = 1'b0;
          out_dh_nxt   = 1'b0;
          state_nxt    = S_CMD;
        end
      end
      S_CMD: begin
        if (out_free) begin
          emit         = 1'b1;
          out_byte_nxt = cmd_r;
          out_last_nxt = (cmd_r > srcap_pkg::CMD_FETCH);
          // command decode
          unique case (cmd_r) inside
            srcap_pkg::CMD_ACK: begin
              hold_nxt  = srcap_pkg::ACK_BYTE;
              state_nxt = S_LAST;
            end
            srcap_pkg::CMD_RD_LIGHT, srcap_pkg::CMD_RD_MIC, srcap_pkg::CMD_RD_LOUD: begin
              sel_nxt = cmd_r[1:0];
              if (cmd_r == srcap_pkg::CMD_RD_LIGHT) begin
                rd_nxt = light_wp_r;
              end else if (cmd_r == srcap_pkg::CMD_RD_MIC) begin
                rd_nxt = mic_wp_r;
              end else begin
                rd_nxt = loud_wp_r;
              end
              state_nxt = S_ARG;
            end
            srcap_pkg::CMD_THR_LIGHT: begin
              light_thr_nxt = arg_r;
              hold_nxt      = arg_r;
              state_nxt     = S_LAST;
            end
            srcap_pkg::CMD_THR_LOUD: begin
              loud_thr_nxt = arg_r;
              hold_nxt     = arg_r;
              state_nxt    = S_LAST;
            end
            srcap_pkg::CMD_FETCH: begin
              state_nxt = S_FETCH;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_ARG: begin
        if (out_free) begin
          emit         = 1'b1;
          out_byte_nxt = arg_r;
          out_last_nxt = 1'b0;
          cnt_nxt      = sat_len;
          if (sat_len != '0) begin
            rd_en  = 1'b1;
            rd_nxt = rd_addr;
          end
          state_nxt = S_DATA;
        end
      end
      S_DATA: begin
        if (out_free) begin
          emit = 1'b1;
          if (cnt_r == '0) begin
            out_byte_nxt = srcap_pkg::STOP_BYTE;
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            out_byte_nxt = ring_q;
            out_last_nxt = 1'b0;
            cnt_nxt      = cnt_r - 1'b1;
            // prefetch the next older entry
            if (cnt_r != CNT_W'(1)) begin
              rd_en  = 1'b1;
              rd_nxt = rd_addr;
            end
          end
        end
      end
      S_FETCH: begin
        if (out_free) begin
          emit          = 1'b1;
          out_byte_nxt  = light_lat_r;
          out_last_nxt  = 1'b0;
          hold_nxt      = loud_lat_r;
          light_lat_nxt = 8'd0;
          loud_lat_nxt  = 8'd0;
          state_nxt     = S_LAST;
        end
      end
      S_LAST: begin
        if (out_free) begin
          emit         = 1'b1;
          out_byte_nxt = hold_r;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      light_wp_r  <= '0;
      mic_wp_r    <= '0;
      loud_wp_r   <= '0;
      light_thr_r <= 8'd0;
      loud_thr_r  <= 8'd0;
      light_lat_r <= 8'd0;
      loud_lat_r  <= 8'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      light_wp_r  <= light_wp_nxt;
      mic_wp_r    <= mic_wp_nxt;
      loud_wp_r   <= loud_wp_nxt;
      light_thr_r <= light_thr_nxt;
      loud_thr_r  <= loud_thr_nxt;
      light_lat_r <= light_lat_nxt;
      loud_lat_r  <= loud_lat_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    arg_r      <= arg_nxt;
    light_r    <= light_nxt;
    loud_r     <= loud_nxt;
    sel_r      <= sel_nxt;
    hold_r     <= hold_nxt;
    lh_r       <= lh_nxt;
    dh_r       <= dh_nxt;
    rd_r       <= rd_nxt;
    cnt_r      <= cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_irq_r  <= out_irq_nxt;
    out_lh_r   <= out_lh_nxt;
    out_dh_r   <= out_dh_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.reply_byte = out_byte_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.irq_pulses = out_irq_r;
  assign out_ch.light_hit  = out_lh_r;
  assign out_ch.loud_hit   = out_lh_r ? 1'b1 & out_dh_r : out_dh_r;

  // the block is not ready in the cycle after it accepts a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("block ready right after accepting a transaction");

  // interrupt pulses only appear on a tick result, which is always last
  a_irq_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.irq_pulses != 2'd0)) |-> out_ch.last)
    else $error("tick result not marked last");

  // pulse count matches the hit flags
  a_irq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.irq_pulses != 2'd0)) |->
    (out_ch.irq_pulses == 2'd1 + {1'b0, out_ch.light_hit} + {1'b0, out_ch.loud_hit}))
    else $error("interrupt pulse count disagrees with hits");

  // read length never exceeds the ring depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DATA) |-> (32'(cnt_r) <= srcap_pkg::RING_DEPTH))
    else $error("read count beyond ring depth");

endmodule
